@@ rtl/core/osc_pkg.sv @@
// ----------------------------------------------------------------------------
// osc_pkg: shared types and constants
// Entry, transaction and cell command types for the ordered sequence store.
// ----------------------------------------------------------------------------
`default_nettype none

package osc_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = $clog2(CAPACITY + 3);

  localparam logic [31:0] START_SITE  = 32'h0000_0000;
  localparam logic [63:0] START_CLOCK = 64'h0;
  localparam logic [31:0] END_SITE    = 32'hFFFF_FFFF;
  localparam logic [63:0] END_CLOCK   = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_LOC_INS = 2'd0,
    KIND_LOC_DEL = 2'd1,
    KIND_REM_INS = 2'd2,
    KIND_REM_DEL = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] clock;
    logic [31:0] site;
    logic [31:0] chr;
    logic        gone;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  position;
    logic [31:0] id_site;
    logic [63:0] id_clock;
    logic [31:0] value;
    logic [31:0] left_site;
    logic [63:0] left_clock;
    logic [31:0] right_site;
    logic [63:0] right_clock;
    logic [63:0] stamp;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        op_delete;
    logic [31:0] out_id_site;
    logic [63:0] out_id_clock;
    logic [31:0] out_value;
    logic [31:0] out_left_site;
    logic [63:0] out_left_clock;
    logic [31:0] out_right_site;
    logic [63:0] out_right_clock;
    logic [63:0] out_stamp;
    logic [8:0]  visible_count;
  } out_t;

  typedef struct packed {
    logic             rotate;
    logic             mark;
    logic             insert;
    logic [IDX_W-1:0] ins_idx;
    entry_t           new_entry;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/ordered_sequence_crdt_store.sv @@
// ----------------------------------------------------------------------------
// ordered_sequence_crdt_store: replicated sequence list
// Ordered character list with ids, tombstones, local and remote edits.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_valid_i / in_stall_o) carry one edit operation;
//   output transactions (out_valid_o / out_stall_i) carry one result each.
//   cfg_we_i writes the local site number from cfg_data_i; the user must
//   write it only while idle, as the block itself does not enforce this.
//   The list lives in a ring of CAPACITY cells. Every lookup rotates the
//   ring once past a single scanner at the head, one cell per cycle. A local
//   insert into a full list skips the ring; deletes and remote inserts take
//   one pass; a local insert takes a neighbor pass and a placement pass.
//   One transaction is in flight at a time; in_stall_o is high while busy.
//   A finished result waits in the output register while the receiver
//   stalls; the next transaction is accepted meanwhile, and its result is
//   held back until the register frees up.
//   Reset empties the list and clears the logical clock; site resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_sequence_crdt_store (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  osc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output osc_pkg::out_t  out_data_o,
  input  wire            cfg_we_i,
  input  wire  [31:0]    cfg_data_i
);

  import osc_pkg::*;

  cell_cmd_t cmd;
  entry_t    cells [CAPACITY];
  entry_t    tail_in;

  // wrap the head back to the tail, tombstoned when the scanner marks it
  always_comb begin
    tail_in      = cells[0];
    tail_in.gone = cells[0].gone | cmd.mark;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    osc_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .prev_i  (cells[(g == 0) ? 0 : g - 1]),
      .next_i  ((g == CAPACITY - 1) ? tail_in : cells[(g == CAPACITY - 1) ? 0 : g + 1]),
      .entry_o (cells[g])
    );
  end

  osc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (cells[0]),
    .cmd_o       (cmd)
  );

endmodule

`default_nettype wire

@@ rtl/core/osc_cell.sv @@
// ----------------------------------------------------------------------------
// osc_cell: one list slot
// Holds one entry; rotates toward the head or shifts right on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_cell (
  input  wire                      clk_i,
  input  wire  [osc_pkg::IDX_W-1:0] idx_i,
  input  osc_pkg::cell_cmd_t       cmd_i,
  input  osc_pkg::entry_t          prev_i,
  input  osc_pkg::entry_t          next_i,
  output osc_pkg::entry_t          entry_o
);

  import osc_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rotate) begin
      entry_q <= next_i;
    end else if (cmd_i.insert) begin
      if (idx_i == cmd_i.ins_idx) begin
        entry_q <= cmd_i.new_entry;
      end else if (idx_i > cmd_i.ins_idx) begin
        entry_q <= prev_i;
      end
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ rtl/core/osc_ctrl.sv @@
// ----------------------------------------------------------------------------
// osc_ctrl: sequencer and head scanner
// Walks the rotating cell ring, resolves positions and ids, drives inserts.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  osc_pkg::in_t        in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output osc_pkg::out_t       out_data_o,
  input  wire                 cfg_we_i,
  input  wire  [31:0]         cfg_data_i,
  input  osc_pkg::entry_t     head_i,
  output osc_pkg::cell_cmd_t  cmd_o
);

  import osc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PASS1 = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_PLACE = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic             stop;
    logic [POS_W-1:0] pos;
  } place_t;

  function automatic place_t place_step(
    input place_t           p,
    input logic [63:0]      c,
    input logic [31:0]      s,
    input logic [POS_W-1:0] i,
    input logic [63:0]      lc,
    input logic [31:0]      ls,
    input logic [63:0]      rc,
    input logic [31:0]      rs,
    input logic [63:0]      nc,
    input logic [31:0]      ns
  );
    place_t r;
    logic   less;
    r    = p;
    less = (c < nc) || ((c == nc) && (s < ns));
    if (!p.stop) begin
      if (c == lc && s == ls) begin
        r.pos = i + POS_W'(1);
      end else if (c == rc && s == rs) begin
        r.stop = 1'b1;
      end else if (i >= p.pos && less) begin
        r.pos = i + POS_W'(1);
      end
    end
    return r;
  endfunction

  state_e           state_q;
  in_t              in_q;
  logic [31:0]      site_q;
  logic [63:0]      clock_q;
  logic [CNT_W-1:0] total_q, viscnt_q, vis_q;
  logic [IDX_W-1:0] k_q, ins_idx_q;
  logic             hit_q, found_q, present_q, full_q;
  place_t           place_q;
  logic [63:0]      lc_q, rc_q, oclk_q;
  logic [31:0]      ls_q, rs_q, osite_q;
  out_t             out_q;
  logic             out_valid_q;

  logic             accept, active, vis_eq, id_eq, last_step, mark;
  logic [POS_W-1:0] i_cur, end_i, pos_fix;
  place_t           step_p, start_p, end_p;
  kind_e            kind, in_kind;
  out_t             res;

  assign kind      = kind_e'(in_q.kind);
  assign in_kind   = kind_e'(in_data_i.kind);
  assign accept    = in_valid_i && state_q == S_IDLE;
  assign active    = total_q > CNT_W'(k_q);
  assign vis_eq    = 32'(vis_q) == 32'(in_q.position);
  assign id_eq     = head_i.clock == in_q.id_clock && head_i.site == in_q.id_site;
  assign last_step = k_q == IDX_W'(CAPACITY - 1);
  assign i_cur     = POS_W'(k_q) + POS_W'(1);
  assign end_i     = POS_W'(total_q) + POS_W'(1);

  assign step_p  = place_step(place_q, head_i.clock, head_i.site, i_cur,
                              lc_q, ls_q, rc_q, rs_q, oclk_q, osite_q);
  assign start_p = place_step('0, START_CLOCK, START_SITE, '0,
                              lc_q, ls_q, rc_q, rs_q, oclk_q, osite_q);
  assign end_p   = place_step(place_q, END_CLOCK, END_SITE, end_i,
                              lc_q, ls_q, rc_q, rs_q, oclk_q, osite_q);

  always_comb begin
    pos_fix = end_p.pos;
    if (pos_fix < POS_W'(1)) pos_fix = POS_W'(1);
    if (pos_fix > end_i) pos_fix = end_i;
  end

  always_comb begin
    mark = 1'b0;
    if (state_q == S_PASS1 && active && !hit_q) begin
      if (kind == KIND_LOC_DEL) mark = !head_i.gone && vis_eq;
      if (kind == KIND_REM_DEL) mark = id_eq;
    end
  end

  always_comb begin
    cmd_o.rotate          = state_q == S_PASS1 || state_q == S_PLACE;
    cmd_o.mark            = mark;
    cmd_o.insert          = state_q == S_SHIFT;
    cmd_o.ins_idx         = ins_idx_q;
    cmd_o.new_entry.clock = oclk_q;
    cmd_o.new_entry.site  = osite_q;
    cmd_o.new_entry.chr   = in_q.value;
    cmd_o.new_entry.gone  = 1'b0;
  end

  // assemble the result from the held transaction state
  always_comb begin
    res = '0;
    res.op_delete     = kind == KIND_LOC_DEL || kind == KIND_REM_DEL;
    res.out_id_site   = osite_q;
    res.out_id_clock  = oclk_q;
    res.out_stamp     = clock_q;
    res.visible_count = 9'(viscnt_q);
    case (kind)
      KIND_LOC_INS: begin
        res.status = full_q ? ST_FULL : ST_DONE;
      end
      KIND_REM_INS: begin
        res.status = present_q ? ST_DUPLICATE : (full_q ? ST_FULL : ST_DONE);
      end
      default: begin
        res.status = hit_q ? ST_DONE : ST_NOT_FOUND;
      end
    endcase
    if ((kind == KIND_LOC_INS && !full_q) || kind == KIND_REM_INS) begin
      res.out_value       = in_q.value;
      res.out_left_site   = ls_q;
      res.out_left_clock  = lc_q;
      res.out_right_site  = rs_q;
      res.out_right_clock = rc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      site_q      <= 32'd1;
      clock_q     <= '0;
      total_q     <= '0;
      viscnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) site_q <= cfg_data_i;
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            in_q      <= in_data_i;
            k_q       <= '0;
            vis_q     <= '0;
            hit_q     <= 1'b0;
            found_q   <= 1'b0;
            full_q    <= total_q == CNT_W'(CAPACITY);
            present_q <= (in_kind == KIND_REM_INS) &&
                         ((in_data_i.id_clock == START_CLOCK &&
                           in_data_i.id_site == START_SITE) ||
                          (in_data_i.id_clock == END_CLOCK &&
                           in_data_i.id_site == END_SITE));
            place_q   <= place_step('0, START_CLOCK, START_SITE, '0,
                                    in_data_i.left_clock, in_data_i.left_site,
                                    in_data_i.right_clock, in_data_i.right_site,
                                    in_data_i.id_clock, in_data_i.id_site);
            case (in_kind)
              KIND_LOC_INS: begin
                lc_q <= START_CLOCK;
                ls_q <= START_SITE;
                rc_q <= END_CLOCK;
                rs_q <= END_SITE;
                if (total_q == CNT_W'(CAPACITY)) begin
                  osite_q <= '0;
                  oclk_q  <= '0;
                  state_q <= S_DONE;
                end else begin
                  clock_q <= clock_q + 64'd1;
                  osite_q <= site_q;
                  oclk_q  <= clock_q + 64'd1;
                  state_q <= S_PASS1;
                end
              end
              KIND_LOC_DEL: begin
                osite_q <= '0;
                oclk_q  <= '0;
                state_q <= S_PASS1;
              end
              default: begin
                lc_q    <= in_data_i.left_clock;
                ls_q    <= in_data_i.left_site;
                rc_q    <= in_data_i.right_clock;
                rs_q    <= in_data_i.right_site;
                osite_q <= in_data_i.id_site;
                oclk_q  <= in_data_i.id_clock;
                state_q <= S_PASS1;
                if (in_data_i.stamp > clock_q) clock_q <= in_data_i.stamp;
              end
            endcase
          end
        end
        S_PASS1: begin
          // the scan index wraps back to zero after the last cell
          k_q <= k_q + IDX_W'(1);
          if (active) begin
            case (kind)
              KIND_LOC_INS: begin
                if (!head_i.gone && !found_q) begin
                  if (vis_eq) begin
                    rc_q    <= head_i.clock;
                    rs_q    <= head_i.site;
                    found_q <= 1'b1;
                  end else begin
                    lc_q  <= head_i.clock;
                    ls_q  <= head_i.site;
                    vis_q <= vis_q + CNT_W'(1);
                  end
                end
              end
              KIND_LOC_DEL: begin
                if (!head_i.gone && !hit_q) begin
                  if (vis_eq) begin
                    hit_q    <= 1'b1;
                    osite_q  <= head_i.site;
                    oclk_q   <= head_i.clock;
                    viscnt_q <= viscnt_q - CNT_W'(1);
                  end else begin
                    vis_q <= vis_q + CNT_W'(1);
                  end
                end
              end
              KIND_REM_INS: begin
                if (id_eq) present_q <= 1'b1;
                place_q <= step_p;
              end
              default: begin
                if (mark) begin
                  hit_q <= 1'b1;
                  if (!head_i.gone) viscnt_q <= viscnt_q - CNT_W'(1);
                end
              end
            endcase
          end
          if (last_step) begin
            case (kind)
              KIND_LOC_INS: state_q <= S_PREP;
              KIND_REM_INS: state_q <= S_FIN;
              default:      state_q <= S_DONE;
            endcase
          end
        end
        S_PREP: begin
          place_q <= start_p;
          state_q <= S_PLACE;
        end
        S_PLACE: begin
          k_q <= k_q + IDX_W'(1);
          if (active) place_q <= step_p;
          if (last_step) state_q <= S_FIN;
        end
        S_FIN: begin
          ins_idx_q <= IDX_W'(pos_fix - POS_W'(1));
          // drop duplicates and inserts into a full list
          if (present_q || full_q) state_q <= S_DONE;
          else                     state_q <= S_SHIFT;
        end
        S_SHIFT: begin
          total_q  <= total_q + CNT_W'(1);
          viscnt_q <= viscnt_q + CNT_W'(1);
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: ordered sequence store testbench
// Drives edit transactions with random gaps and stalls and compares every
// result with a behavioral copy of the list kept in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import osc_pkg::*;

class list_scoreboard;
  logic [63:0] clk_of [CAPACITY];
  logic [31:0] site_of [CAPACITY];
  logic [31:0] chr_of [CAPACITY];
  bit          gone_of [CAPACITY];
  int          total;
  logic [63:0] lclock;
  logic [31:0] site;
  out_t        pending [$];
  int          mismatches;

  function void clear();
    total = 0; lclock = '0; site = 32'd1; pending.delete(); mismatches = 0;
  endfunction

  function bit id_lt(logic [63:0] ca, logic [31:0] sa, logic [63:0] cb, logic [31:0] sb);
    if (ca != cb) return ca < cb;
    return sa < sb;
  endfunction

  function int visible();
    int n;
    n = 0;
    for (int i = 0; i < total; i++) if (!gone_of[i]) n++;
    return n;
  endfunction

  function bit known(logic [63:0] c, logic [31:0] s);
    if (c == START_CLOCK && s == START_SITE) return 1;
    if (c == END_CLOCK && s == END_SITE) return 1;
    for (int i = 0; i < total; i++) if (clk_of[i] == c && site_of[i] == s) return 1;
    return 0;
  endfunction

  function int slot(logic [63:0] nc, logic [31:0] ns, logic [63:0] lc, logic [31:0] ls,
                    logic [63:0] rc, logic [31:0] rs);
    int p;
    logic [63:0] c;
    logic [31:0] s;
    p = 0;
    for (int i = 0; i <= total + 1; i++) begin
      if (i == 0) begin
        c = START_CLOCK; s = START_SITE;
      end else if (i == total + 1) begin
        c = END_CLOCK; s = END_SITE;
      end else begin
        c = clk_of[i-1]; s = site_of[i-1];
      end
      if (c == lc && s == ls) begin
        p = i + 1;
        continue;
      end
      if (c == rc && s == rs) break;
      if (i >= p && id_lt(c, s, nc, ns)) p = i + 1;
    end
    if (p < 1) p = 1;
    if (p > total + 1) p = total + 1;
    return p - 1;
  endfunction

  function void place(int idx, logic [63:0] c, logic [31:0] s, logic [31:0] v);
    for (int i = total; i > idx; i--) begin
      clk_of[i] = clk_of[i-1]; site_of[i] = site_of[i-1];
      chr_of[i] = chr_of[i-1]; gone_of[i] = gone_of[i-1];
    end
    clk_of[idx] = c; site_of[idx] = s; chr_of[idx] = v; gone_of[idx] = 0;
    total++;
  endfunction

  // Note an accepted transaction and queue its expected result.
  function void note_edit(in_t t);
    out_t r;
    int vis;
    logic [63:0] lc, rc;
    logic [31:0] ls, rs;
    r = '0;
    r.op_delete = (t.kind == KIND_LOC_DEL || t.kind == KIND_REM_DEL);
    case (kind_e'(t.kind))
      KIND_LOC_INS: begin
        if (total >= CAPACITY) r.status = ST_FULL;
        else begin
          ls = START_SITE; lc = START_CLOCK; rs = END_SITE; rc = END_CLOCK; vis = 0;
          lclock++;
          for (int i = 0; i < total; i++) begin
            if (gone_of[i]) continue;
            if (vis == t.position) begin
              rc = clk_of[i]; rs = site_of[i];
              break;
            end
            lc = clk_of[i]; ls = site_of[i];
            vis++;
          end
          place(slot(lclock, site, lc, ls, rc, rs), lclock, site, t.value);
          r.status = ST_DONE; r.out_id_site = site; r.out_id_clock = lclock;
          r.out_value = t.value; r.out_left_site = ls; r.out_left_clock = lc;
          r.out_right_site = rs; r.out_right_clock = rc;
        end
      end
      KIND_LOC_DEL: begin
        vis = 0;
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < total; i++) begin
          if (gone_of[i]) continue;
          if (vis == t.position) begin
            gone_of[i] = 1;
            r.status = ST_DONE; r.out_id_site = site_of[i]; r.out_id_clock = clk_of[i];
            break;
          end
          vis++;
        end
      end
      default: begin
        if (t.stamp > lclock) lclock = t.stamp;
        r.out_id_site = t.id_site; r.out_id_clock = t.id_clock;
        if (t.kind == KIND_REM_INS) begin
          r.out_value = t.value;
          r.out_left_site = t.left_site; r.out_left_clock = t.left_clock;
          r.out_right_site = t.right_site; r.out_right_clock = t.right_clock;
          if (known(t.id_clock, t.id_site)) r.status = ST_DUPLICATE;
          else if (total >= CAPACITY) r.status = ST_FULL;
          else begin
            r.status = ST_DONE;
            place(slot(t.id_clock, t.id_site, t.left_clock, t.left_site,
                       t.right_clock, t.right_site), t.id_clock, t.id_site, t.value);
          end
        end else begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < total; i++)
            if (clk_of[i] == t.id_clock && site_of[i] == t.id_site) begin
              gone_of[i] = 1;
              r.status = ST_DONE;
              break;
            end
        end
      end
    endcase
    r.out_stamp = lclock;
    r.visible_count = 9'(visible());
    pending = {pending, r};
  endfunction

  function void check_result(out_t got);
    out_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected %h", want);
        $display("          actual   %h", got);
      end
    end
  endfunction
endclass

module tb_top;
  localparam int WATCHDOG = 40000;

  logic  clk_i = 0;
  logic  rst_ni = 0;
  logic  in_valid_i = 0;
  logic  in_stall_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1;
  out_t  out_data_o;
  logic  cfg_we_i = 0;
  logic [31:0] cfg_data_i = '0;

  list_scoreboard board = new();
  int    idle_cycles;
  bit    hold_off;
  bit    free_run;

  // recent ids, for remote ops that hit existing entries
  logic [63:0] seen_clk [$];
  logic [31:0] seen_site [$];

  ordered_sequence_crdt_store uut (.*);

  always #10 clk_i = ~clk_i;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (free_run || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1;
        repeat (3000) @(negedge clk_i);
        hold_off = 0;
      end
      g = pick_gap();
      out_stall_i <= (g != 0);
      if (g > 1) repeat (g - 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i)
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end

  // Called at a falling edge; valid stays high after acceptance until the
  // next gap or the next drain drops it.
  task automatic send(in_t t);
    int g;
    g = pick_gap();
    if (g != 0) begin
      in_valid_i <= 0;
      repeat (g) @(negedge clk_i);
    end
    in_data_i <= t;
    in_valid_i <= 1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_edit(t);
    if (t.kind == KIND_LOC_INS || t.kind == KIND_REM_INS) begin
      seen_clk = {seen_clk, board.pending[$].out_id_clock};
      seen_site = {seen_site, board.pending[$].out_id_site};
      if (seen_clk.size() > 64) begin
        void'(seen_clk.pop_front()); void'(seen_site.pop_front());
      end
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY + 20) @(posedge clk_i);
  endtask

  task automatic set_site(logic [31:0] s);
    @(negedge clk_i);
    cfg_data_i <= s;
    cfg_we_i <= 1;
    @(negedge clk_i);
    cfg_we_i <= 0;
    board.site = s;
  endtask

  function automatic in_t rand_edit(bit wide);
    in_t t;
    logic [415:0] raw;
    int k, r;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    t = raw[$bits(in_t)-1:0];
    k = $urandom_range(0, 99);
    t.kind = k < 40 ? KIND_LOC_INS : k < 60 ? KIND_LOC_DEL : k < 85 ? KIND_REM_INS
           : KIND_REM_DEL;
    t.position = wide ? 9'($urandom_range(0, 256))
                      : 9'($urandom_range(0, board.visible() + 2));
    if (!wide) t.stamp = board.lclock + $urandom_range(0, 5) - 2;
    r = $urandom_range(0, 9);
    if (seen_clk.size() != 0 && r < 7) begin
      k = $urandom_range(0, seen_clk.size() - 1);
      t.id_clock = seen_clk[k]; t.id_site = seen_site[k];
      if (t.kind == KIND_REM_INS && r < 5) begin
        t.id_clock = board.lclock + 1 + $urandom_range(0, 3);
        t.id_site = $urandom_range(1, 6);
      end
      k = $urandom_range(0, seen_clk.size() - 1);
      t.left_clock = seen_clk[k]; t.left_site = seen_site[k];
      k = $urandom_range(0, seen_clk.size() - 1);
      t.right_clock = seen_clk[k]; t.right_site = seen_site[k];
      if (r == 0) begin
        t.left_clock = START_CLOCK; t.left_site = START_SITE;
      end
      if (r == 1) begin
        t.right_clock = END_CLOCK; t.right_site = END_SITE;
      end
    end
    return t;
  endfunction

  initial begin
    in_t t;
    board.clear();
    hold_off = 0;
    free_run = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: empty list, sentinels, extremes
    t = '0; t.kind = KIND_LOC_DEL; send(t);
    t = '0; t.kind = KIND_REM_DEL; send(t);
    t = '0; t.kind = KIND_REM_INS; send(t);
    t = '0; t.kind = KIND_REM_INS; t.id_site = END_SITE; t.id_clock = END_CLOCK; send(t);
    t = '0; t.kind = KIND_LOC_INS; t.value = 32'h41; send(t);
    t = '0; t.kind = KIND_LOC_INS; t.position = 9'd256; t.value = '1; send(t);
    t = '0; t.kind = KIND_LOC_INS; t.position = 9'd1; t.value = 32'h43; send(t);
    t = '1; t.kind = KIND_REM_INS; t.id_clock = 64'd2; t.id_site = 32'd7;
    t.left_clock = START_CLOCK; t.left_site = START_SITE; t.stamp = 64'd1; send(t);
    t = '1; t.kind = KIND_REM_INS; t.id_clock = 64'd1; t.id_site = 32'd1; send(t);
    t = '0; t.kind = KIND_REM_DEL; t.id_clock = 64'd2; t.id_site = 32'd7; send(t);
    t = '0; t.kind = KIND_REM_DEL; t.id_clock = 64'd2; t.id_site = 32'd7; send(t);
    t = '0; t.kind = KIND_LOC_DEL; t.position = 9'd256; send(t);
    t = '0; t.kind = KIND_LOC_DEL; t.position = 9'd1; send(t);
    t = '0; t.kind = KIND_REM_DEL; t.id_clock = END_CLOCK; t.id_site = END_SITE; send(t);
    drain();
    set_site(32'hFFFF_FFFE);
    t = '0; t.kind = KIND_LOC_INS; t.position = 9'd0; t.value = 32'h10FFFF; send(t);
    t = '0; t.kind = KIND_REM_INS; t.id_clock = 64'd50; t.id_site = 32'd3; t.stamp = '1;
    t.right_clock = END_CLOCK; t.right_site = END_SITE; send(t);
    // clock wraps on the next local insert
    t = '0; t.kind = KIND_LOC_INS; t.position = 9'd1; send(t);
    drain();
    set_site(32'd1);

    // fill to capacity while the receiver holds off
    hold_off = 1;
    for (int i = 0; i < CAPACITY + 4; i++) begin
      t = rand_edit(0);
      t.kind = (i % 3 == 0) ? KIND_REM_INS : KIND_LOC_INS;
      if (t.kind == KIND_REM_INS) begin
        t.id_clock = board.lclock + 3; t.id_site = $urandom_range(2, 9);
      end
      send(t);
    end
    t = rand_edit(1); t.kind = KIND_REM_INS; send(t);
    drain();

    // random phases with differing site numbers; list keeps its history
    for (int ph = 0; ph < 6; ph++) begin
      free_run = (ph == 2);
      case (ph)
        1: set_site(32'hFFFF_FFFE);
        3: set_site($urandom_range(2, 1000));
        5: set_site(32'd1);
        default: ;
      endcase
      for (int i = 0; i < 270; i++) begin
        t = rand_edit(i % 10 == 0);
        if (board.total >= CAPACITY - 8 && t.kind == KIND_LOC_INS && i % 4 != 0)
          t.kind = KIND_LOC_DEL;
        send(t);
      end
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/osc_pkg.sv
rtl/core/osc_cell.sv
rtl/core/osc_ctrl.sv
rtl/core/ordered_sequence_crdt_store.sv
tb/tb_top.sv
